[rtl/core/fhal_pkg.sv]
// ----------------------------------------------------------------------------
// fhal_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package fhal_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int HDR_BYTES      = 5;
  localparam int SPLIT_SLACK    = 10;
  localparam int SIZE_W         = 12;
  localparam int ST_W           = 3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FMT,
    S_WALK,
    S_WAIT,
    S_SPLIT,
    S_NWAIT,
    S_MERGE,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    take;
    logic    load;
    logic    fmt;
    logic    rd_h;
    logic    rd_nxt;
    logic    adv;
    logic    hold_sz;
    logic    add_nxt;
    logic    wr_rest;
    logic    wr_h_used;
    logic    wr_merge;
    logic    set_code;
    status_t code;
    logic    fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_alloc;
    logic in_zero;
    logic free_bad;
    logic formatted;
    logic op_alloc;
    logic h_end;
    logic fit;
    logic split;
    logic is_target;
    logic blk_free;
    logic nxt_in;
    logic out_busy;
  } stat_t;

endpackage

[rtl/core/fhal_req_if.sv]
// ----------------------------------------------------------------------------
// fhal_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface fhal_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] request_size;
  logic [11:0] free_offset;

  modport source (output valid, output opcode, output request_size,
                  output free_offset, input ready);
  modport sink   (input valid, input opcode, input request_size,
                  input free_offset, output ready);
endinterface

[rtl/core/fhal_rsp_if.sv]
// ----------------------------------------------------------------------------
// fhal_rsp_if
// Result channel: valid/ready handshake with status and payload offset.
// ----------------------------------------------------------------------------
interface fhal_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] payload_offset;

  modport source (output valid, output status, output payload_offset,
                  input ready);
  modport sink   (input valid, input status, input payload_offset,
                  output ready);
endinterface

[rtl/core/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over an implicit list of heap blocks.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request walks the block headers from
// the start of the heap, with a memory read and then a decision for each
// header visited, over the single port of the header store. Around the walk,
// the item is accepted first and the result register is loaded last.
// The first allocate formats the heap before walking. A split adds a write
// of the rest block's header. A free that merges adds the next header read
// and the merge write, or only the merge write when the block ends at the
// heap end. An allocate that runs off the end of the heap ends with the end
// check. A zero size, or a free before the heap is formatted or with an
// offset outside the heap, goes from acceptance straight to the result. The
// result sits in an output register while the next item is taken in; a
// second result waits in the last state, and holds the input off, until the
// first has been taken. No clearing pass runs after reset: the first
// allocate writes the whole-heap header, and walks only ever read live
// headers.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES = fhal_pkg::HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fhal_req_if.sink    in_req,
  fhal_rsp_if.source  out_rsp
);
  import fhal_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the walk
  fhal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold headers, walk position and the result
  fhal_datapath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

[rtl/core/fhal_datapath.sv]
// ----------------------------------------------------------------------------
// fhal_datapath
// Header store, walk registers and result register of the allocator.
// ----------------------------------------------------------------------------
module fhal_datapath #(
  parameter int HEAP_BYTES = fhal_pkg::HEAP_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  fhal_req_if.sink        in_req,
  fhal_rsp_if.source      out_rsp,
  input  fhal_pkg::cmd_t  cmd,
  output fhal_pkg::stat_t stat
);
  import fhal_pkg::*;

  localparam int AW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
  localparam int SW = $clog2(HEAP_BYTES + 1);
  localparam int CW = ((SW > 13) ? SW : 13) + 1;
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C  = CW'(HDR_BYTES);
  localparam logic [CW-1:0] SLK_C  = CW'(SPLIT_SLACK);

  // entry: free flag on top, block size below
  logic [SW:0]   heap_mem [HEAP_BYTES];
  logic [SW:0]   rdata_r;

  logic          formatted_r;
  logic          op_r;
  logic [11:0]   req_r;
  logic [11:0]   target_r;
  logic [SW-1:0] h_r, sz_r, prev_r, prev_sz_r;
  logic          prev_free_r, have_prev_r;
  status_t       code_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [11:0]   out_pay_r;

  logic [SW-1:0] rsz;
  logic          rfree;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [SW:0]   mem_wdata;
  logic [CW-1:0] req_c, h_c;

  assign rsz   = rdata_r[SW-1:0];
  assign rfree = rdata_r[SW];
  assign req_c = CW'(req_r);
  assign h_c   = CW'(h_r);

  assign in_req.ready = cmd.take;

  always_comb begin
    stat.in_valid  = in_req.valid;
    stat.in_alloc  = (in_req.opcode == OP_ALLOC);
    stat.in_zero   = (in_req.request_size == 12'd0);
    stat.free_bad  = !formatted_r || (CW'(in_req.free_offset) < HDR_C) ||
                     (CW'(in_req.free_offset) - HDR_C >= HEAP_C);
    stat.formatted = formatted_r;
    stat.op_alloc  = (op_r == OP_ALLOC);
    stat.h_end     = (h_c >= HEAP_C) ||
                     ((op_r == OP_FREE) && (h_c > CW'(target_r)));
    stat.fit       = rfree && (CW'(rsz) >= req_c + HDR_C);
    stat.split     = CW'(rsz) > req_c + SLK_C;
    stat.is_target = (h_c == CW'(target_r));
    stat.blk_free  = rfree;
    stat.nxt_in    = (h_c + CW'(rsz)) < HEAP_C;
    stat.out_busy  = out_valid_r && !out_rsp.ready;
  end

  // Memory port select: one write or one read a cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    if (cmd.fmt) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b1, SW'(HEAP_BYTES)};
    end else if (cmd.wr_rest) begin
      mem_we    = 1'b1;
      mem_addr  = AW'(h_c + req_c + HDR_C);
      mem_wdata = {1'b1, SW'(CW'(rsz) - req_c - HDR_C)};
    end else if (cmd.wr_h_used) begin
      mem_we    = 1'b1;
      mem_addr  = AW'(h_r);
      mem_wdata = {1'b0, (stat.split ? SW'(req_c + HDR_C) : rsz)};
    end else if (cmd.wr_merge) begin
      mem_we = 1'b1;
      if (have_prev_r && prev_free_r) begin
        mem_addr  = AW'(prev_r);
        mem_wdata = {1'b1, SW'(prev_sz_r + sz_r)};
      end else begin
        mem_addr  = AW'(h_r);
        mem_wdata = {1'b1, sz_r};
      end
    end else if (cmd.rd_h) begin
      mem_re   = 1'b1;
      mem_addr = AW'(h_r);
    end else if (cmd.rd_nxt) begin
      mem_re   = 1'b1;
      mem_addr = AW'(h_c + CW'(rsz));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_r <= heap_mem[mem_addr];
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_req.opcode;
      req_r    <= in_req.request_size;
      target_r <= in_req.free_offset - 12'(HDR_BYTES);
      h_r      <= '0;
    end else if (cmd.adv) begin
      prev_r    <= h_r;
      prev_sz_r <= rsz;
      h_r       <= h_r + rsz;
    end
    if (cmd.hold_sz) begin
      sz_r <= rsz;
    end else if (cmd.add_nxt && rfree) begin
      sz_r <= sz_r + rsz;
    end
    if (cmd.adv) begin
      prev_free_r <= rfree;
    end
    if (cmd.set_code) begin
      code_r <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      formatted_r  <= 1'b0;
      have_prev_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= '0;
      out_pay_r    <= '0;
    end else begin
      if (cmd.fmt) begin
        formatted_r <= 1'b1;
      end
      if (cmd.load) begin
        have_prev_r <= 1'b0;
      end else if (cmd.adv) begin
        have_prev_r <= 1'b1;
      end
      if (cmd.fin) begin
        out_valid_r  <= 1'b1;
        out_status_r <= code_r;
        out_pay_r    <= ((code_r == ST_OK) && (op_r == OP_ALLOC)) ?
                        12'(h_c + HDR_C) : 12'd0;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.payload_offset = out_pay_r;

endmodule

[rtl/core/fhal_ctrl.sv]
// ----------------------------------------------------------------------------
// fhal_ctrl
// Sequencer for the allocate and free walks.
// ----------------------------------------------------------------------------
module fhal_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  fhal_pkg::stat_t stat,
  output fhal_pkg::cmd_t  cmd
);
  import fhal_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) begin
          if (stat.in_alloc) begin
            if (stat.in_zero)        state_nxt = S_DONE;
            else if (!stat.formatted) state_nxt = S_FMT;
            else                      state_nxt = S_WALK;
          end else begin
            state_nxt = stat.free_bad ? S_DONE : S_WALK;
          end
        end
      end
      S_FMT:  state_nxt = S_WALK;
      S_WALK: state_nxt = stat.h_end ? S_DONE : S_WAIT;
      S_WAIT: begin
        if (stat.op_alloc) begin
          if (!stat.fit)      state_nxt = S_WALK;
          else if (stat.split) state_nxt = S_SPLIT;
          else                 state_nxt = S_DONE;
        end else begin
          if (!stat.is_target)  state_nxt = S_WALK;
          else if (stat.blk_free) state_nxt = S_DONE;
          else if (stat.nxt_in)   state_nxt = S_NWAIT;
          else                    state_nxt = S_MERGE;
        end
      end
      S_SPLIT: state_nxt = S_DONE;
      S_NWAIT: state_nxt = S_MERGE;
      S_MERGE: state_nxt = S_DONE;
      S_DONE:  state_nxt = stat.out_busy ? S_DONE : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.code = ST_OK;
    case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_alloc && stat.in_zero) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_ZERO;
          end else if (!stat.in_alloc && stat.free_bad) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_INVALID;
          end
        end
      end
      S_FMT: cmd.fmt = 1'b1;
      S_WALK: begin
        if (stat.h_end) begin
          cmd.set_code = 1'b1;
          cmd.code     = stat.op_alloc ? ST_OOM : ST_INVALID;
        end else begin
          cmd.rd_h = 1'b1;
        end
      end
      S_WAIT: begin
        if (stat.op_alloc) begin
          if (!stat.fit) begin
            cmd.adv = 1'b1;
          end else if (stat.split) begin
            cmd.wr_rest = 1'b1;
          end else begin
            cmd.wr_h_used = 1'b1;
            cmd.set_code  = 1'b1;
            cmd.code      = ST_OK;
          end
        end else begin
          if (!stat.is_target) begin
            cmd.adv = 1'b1;
          end else if (stat.blk_free) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_DOUBLE;
          end else begin
            cmd.hold_sz = 1'b1;
            cmd.rd_nxt  = stat.nxt_in;
          end
        end
      end
      S_SPLIT: begin
        cmd.wr_h_used = 1'b1;
        cmd.set_code  = 1'b1;
        cmd.code      = ST_OK;
      end
      S_NWAIT: cmd.add_nxt = 1'b1;
      S_MERGE: begin
        cmd.wr_merge = 1'b1;
        cmd.set_code = 1'b1;
        cmd.code     = ST_OK;
      end
      S_DONE: cmd.fin = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

[verif/first_fit_heap_allocator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_tb
// Checks the first-fit heap allocator against a behavioural heap model.
// A queue of requests, built with its own copy of the heap so that frees can
// name live payloads, is fed through a randomly idling driver. Every accepted
// request is predicted on a second heap copy, and a randomly stalling monitor
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top_tb;
  import fhal_pkg::*;

  localparam int HEAP = HEAP_BYTES_DEF;
  localparam logic [7:0] FLAG_FREE = 8'h61;  // 'a'
  localparam logic [7:0] FLAG_USED = 8'h6F;  // 'o'
  localparam int CHK = 0;  // heap copy for prediction of accepted items
  localparam int PLN = 1;  // heap copy used while building the stimulus

  typedef struct {
    opcode_t     op;
    logic [11:0] rsz;
    logic [11:0] foff;
    bit          drain;  // hold this item back until no result is owed
  } heap_req_t;

  typedef struct {
    status_t     st;
    logic [11:0] pay;
  } heap_rsp_t;

  logic clk;
  logic rst_n;

  fhal_req_if req_if ();
  fhal_rsp_if rsp_if ();

  first_fit_heap_allocator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if.sink),
    .out_rsp(rsp_if.source)
  );

  // Two independent copies of the heap state
  logic [7:0] heap_mem [2][HEAP];
  bit         heap_fmt [2];

  heap_req_t pending_reqs[$];
  heap_rsp_t owed_rsps[$];
  int        live_pay[$];  // payload offsets the builder believes are in use
  int        mismatches = 0;
  int        accepted_reqs = 0;
  int        req_gap = 0;
  int        rsp_stall = 0;
  bit        rsp_hold = 0;
  bit        burst_mode = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Heap model
  // --------------------------------------------------------------------------
  function automatic int unsigned hb(int c, int unsigned a);
    return (a < HEAP) ? heap_mem[c][a] : 0;
  endfunction

  function automatic void hb_wr(int c, int unsigned a, int unsigned v);
    if (a < HEAP) heap_mem[c][a] = v[7:0];
  endfunction

  function automatic int unsigned blk_size(int c, int unsigned h);
    return hb(c, h+1) | (hb(c, h+2) << 8) | (hb(c, h+3) << 16) | (hb(c, h+4) << 24);
  endfunction

  function automatic void blk_size_wr(int c, int unsigned h, int unsigned v);
    hb_wr(c, h+1, v);
    hb_wr(c, h+2, v >> 8);
    hb_wr(c, h+3, v >> 16);
    hb_wr(c, h+4, v >> 24);
  endfunction

  function automatic bit blk_sane(int unsigned h, int unsigned sz);
    return sz >= HDR_BYTES && sz <= HEAP - h;
  endfunction

  function automatic status_t heap_alloc(int c, int unsigned req, output int unsigned pay);
    int unsigned h = 0;
    int unsigned sz;
    pay = 0;
    if (req == 0) return ST_ZERO;
    if (!heap_fmt[c]) begin
      hb_wr(c, 0, FLAG_FREE);
      blk_size_wr(c, 0, HEAP);
      heap_fmt[c] = 1;
    end
    while (h < HEAP) begin
      sz = blk_size(c, h);
      if (!blk_sane(h, sz)) return ST_OOM;
      if (hb(c, h) == FLAG_FREE && sz >= req + HDR_BYTES) begin
        if (sz > req + SPLIT_SLACK) begin
          hb_wr(c, h + req + HDR_BYTES, FLAG_FREE);
          blk_size_wr(c, h + req + HDR_BYTES, sz - req - HDR_BYTES);
          blk_size_wr(c, h, req + HDR_BYTES);
        end
        hb_wr(c, h, FLAG_USED);
        pay = h + HDR_BYTES;
        return ST_OK;
      end
      h += sz;
    end
    return ST_OOM;
  endfunction

  function automatic status_t heap_release(int c, int unsigned off);
    int unsigned tgt, h = 0, prv = 0, sz, nxt, nsz;
    bit has_prv = 0;
    if (!heap_fmt[c] || off < HDR_BYTES) return ST_INVALID;
    tgt = off - HDR_BYTES;
    forever begin
      if (h >= HEAP || h > tgt) return ST_INVALID;
      sz = blk_size(c, h);
      if (!blk_sane(h, sz)) return ST_INVALID;
      if (h == tgt) break;
      prv = h;
      has_prv = 1;
      h += sz;
    end
    if (hb(c, h) == FLAG_FREE) return ST_DOUBLE;
    if (hb(c, h) != FLAG_USED) return ST_INVALID;
    hb_wr(c, h, FLAG_FREE);
    nxt = h + sz;
    if (nxt < HEAP && hb(c, nxt) == FLAG_FREE) begin
      nsz = blk_size(c, nxt);
      if (blk_sane(nxt, nsz)) begin
        sz += nsz;
        blk_size_wr(c, h, sz);
        hb_wr(c, nxt, 0);
      end
    end
    // fold into a free predecessor; its header absorbs this block
    if (has_prv && hb(c, prv) == FLAG_FREE) begin
      blk_size_wr(c, prv, blk_size(c, prv) + sz);
      hb_wr(c, h, 0);
    end
    return ST_OK;
  endfunction

  function automatic heap_rsp_t heap_step(int c, heap_req_t r);
    heap_rsp_t   res;
    int unsigned pay = 0;
    if (r.op == OP_ALLOC) res.st = heap_alloc(c, r.rsz, pay);
    else                  res.st = heap_release(c, r.foff);
    res.pay = pay[11:0];
    return res;
  endfunction

  // Queue one request, run it on the builder's heap and track live payloads
  task automatic queue_req(opcode_t op, int unsigned rsz, int unsigned foff, bit drain = 0);
    heap_req_t r;
    heap_rsp_t res;
    r.op    = op;
    r.rsz   = rsz[11:0];
    r.foff  = foff[11:0];
    r.drain = drain;
    res = heap_step(PLN, r);
    if (res.st == ST_OK) begin
      if (op == OP_ALLOC) begin
        live_pay.push_back(res.pay);
      end else begin
        foreach (live_pay[i]) if (live_pay[i] == r.foff) begin
          live_pay.delete(i);
          break;
        end
      end
    end
    pending_reqs.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued items, idle between them, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    heap_req_t r;
    bit        took;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      took = req_if.valid && req_if.ready;
      if (took) begin
        r.op   = opcode_t'(req_if.opcode);
        r.rsz  = req_if.request_size;
        r.foff = req_if.free_offset;
        owed_rsps.push_back(heap_step(CHK, r));
        accepted_reqs++;
      end
      // hold the current item until it is taken
      if (!req_if.valid || took) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain || owed_rsps.size() == 0)) begin
          r = pending_reqs.pop_front();
          req_if.valid        <= 1'b1;
          req_if.opcode       <= r.op;
          req_if.request_size <= r.rsz;
          req_if.free_offset  <= r.foff;
          req_gap = burst_mode ? 0 : $urandom_range(0, 18);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall at random, compare each result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    heap_rsp_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result status=%0d offset=%0d", $realtime,
                     rsp_if.status, rsp_if.payload_offset);
        end else begin
          want = owed_rsps.pop_front();
          if (rsp_if.status !== want.st || rsp_if.payload_offset !== want.pay) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: status exp %0d got %0d, offset exp %0d got %0d", $realtime,
                       want.st, rsp_if.status, want.pay, rsp_if.payload_offset);
          end
        end
        rsp_stall = burst_mode ? 0 : $urandom_range(0, 18);
      end
      if (rsp_hold) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off: the sender keeps offering so the block backs up
  initial begin
    wait (accepted_reqs >= 600);
    @(posedge clk);
    rsp_hold = 1;
    repeat (400) @(posedge clk);
    rsp_hold = 0;
  end

  // Alternate idling phases with stretches of back-to-back traffic
  initial begin
    forever begin
      repeat ($urandom_range(500, 3000)) @(posedge clk);
      burst_mode = ~burst_mode;
    end
  end

  initial begin
    #60ms;
    $display("first_fit_heap_allocator_top: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick, sz;
    req_if.valid        = 1'b0;
    req_if.opcode       = 1'b0;
    req_if.request_size = '0;
    req_if.free_offset  = '0;
    rsp_if.ready        = 1'b0;
    rst_n               = 1'b0;
    foreach (heap_mem[c, a]) heap_mem[c][a] = 8'h00;
    heap_fmt[0] = 0;
    heap_fmt[1] = 0;

    // Directed: zero size, free before format, whole heap, limits, splits
    queue_req(OP_ALLOC, 0, 12'hFFF);
    queue_req(OP_FREE, 12'hFFF, 5);        // nothing formatted yet
    queue_req(OP_ALLOC, 4095, 0);          // larger than the heap
    queue_req(OP_ALLOC, 4091, 0);          // exactly the whole heap, no split
    queue_req(OP_ALLOC, 1, 0);             // heap full
    queue_req(OP_FREE, 0, 0);              // offset below header size
    queue_req(OP_FREE, 0, 4);
    queue_req(OP_FREE, 0, 5);
    queue_req(OP_FREE, 0, 5);              // double free
    queue_req(OP_ALLOC, 1, 0);             // split off a 6-byte block
    queue_req(OP_ALLOC, 6, 0);             // split again, an 11-byte block
    queue_req(OP_ALLOC, 3, 0);
    queue_req(OP_FREE, 0, 7);              // not on a header
    queue_req(OP_FREE, 0, 4095);           // header near end, no match
    queue_req(OP_FREE, 0, 11);
    queue_req(OP_FREE, 0, 5);              // merge with free successor
    queue_req(OP_FREE, 0, 22);             // merge with free neighbours on both sides
    queue_req(OP_ALLOC, 2048, 0);
    queue_req(OP_ALLOC, 2048, 0);          // out of memory
    queue_req(OP_ALLOC, 12'hAAA, 12'h555);
    queue_req(OP_FREE, 12'h555, 12'hAAA);
    while (live_pay.size() > 0) queue_req(OP_FREE, 0, live_pay[0]);

    // Random: mostly well-formed alloc/free with live payloads, some noise
    for (int n = 0; n < 1600; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50 || live_pay.size() == 0) begin
        sz = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 160);
        queue_req(OP_ALLOC, sz, $urandom, n == 1000);
      end else if (pick < 90) begin
        queue_req(OP_FREE, $urandom, live_pay[$urandom_range(0, live_pay.size() - 1)],
                  n == 1000);
      end else if (pick < 93) begin
        queue_req(OP_ALLOC, 0, $urandom, n == 1000);
      end else if (pick < 96) begin
        // offset near a live payload: misaligned or stale
        queue_req(OP_FREE, $urandom,
                  live_pay[$urandom_range(0, live_pay.size() - 1)] + $urandom_range(0, 12) - 6,
                  n == 1000);
      end else begin
        queue_req(OP_FREE, $urandom, $urandom_range(0, 4095), n == 1000);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || owed_rsps.size() > 0 || req_if.valid)
      @(posedge clk);
    repeat (1500) @(posedge clk);

    if (mismatches == 0 && owed_rsps.size() == 0)
      $display("first_fit_heap_allocator_top: match");
    else
      $display("first_fit_heap_allocator_top: mismatch");
    $finish;
  end

endmodule
